// ----- sv/mccm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI control-change mapper package
// Shared types, register indexes, reset values and a helper function.
// ----------------------------------------------------------------------------
package mccm_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int POT_COUNT    = 4;
  localparam int SLOT_COUNT   = (BUTTON_COUNT > POT_COUNT) ? BUTTON_COUNT : POT_COUNT;
  localparam int SLOT_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [9:0]  THRESHOLD_RST = 10'd8;
  localparam logic [31:0] BTN_LOW_RST   = 32'd44106369;
  localparam logic [31:0] BTN_HIGH_RST  = 32'd48300737;
  localparam logic [25:0] POT0_RST      = 26'd66585537;
  localparam logic [25:0] POT1_RST      = 26'd66585569;
  localparam logic [25:0] POT2_RST      = 26'd66585601;
  localparam logic [25:0] POT3_RST      = 26'd66585633;

  localparam logic [7:0] CC_STATUS  = 8'hB0;
  localparam logic [6:0] CC_VAL_MAX = 7'd127;
  localparam logic [6:0] CC_VAL_MIN = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_BTN_LOW   = 3'd1,
    REG_BTN_HIGH  = 3'd2,
    REG_POT0      = 3'd3,
    REG_POT1      = 3'd4,
    REG_POT2      = 3'd5,
    REG_POT3      = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    CMD_BUTTON = 1'b0,
    CMD_POT    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic              pressed;
    logic [9:0]        sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [6:0] controller_number;
    logic [6:0] controller_value;
  } out_item_t;

  // One state memory entry per slot.
  typedef struct packed {
    logic       toggle;
    logic [9:0] last_sample;
    logic [7:0] last_value;
  } entry_t;

  localparam int     ENTRY_W   = $bits(entry_t);
  localparam entry_t ENTRY_RST = '{toggle: 1'b0, last_sample: 10'd0, last_value: 8'hFF};

  // Status byte for a 5-bit channel field, clamped to channels 1..16.
  function automatic logic [7:0] status_for(input logic [4:0] chan);
    logic [3:0] ch;
    if (chan == 5'd0) begin
      ch = 4'd0;
    end else if (chan > 5'd16) begin
      ch = 4'd15;
    end else begin
      ch = 4'(chan - 5'd1);
    end
    return CC_STATUS | {4'd0, ch};
  endfunction

endpackage

// ----- sv/midi_control_change_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI control-change mapper
// Turns button edge events and pot samples into MIDI control-change requests.
// ----------------------------------------------------------------------------
// The block takes one request per clock while input stall is low and returns
// at most one control-change request for it, registered in stage 1 and then in
// the output register. The per-slot state (toggle bit, last kept sample, last
// sent value) lives in a four-entry memory with a registered read port. The
// read is issued when a request is accepted and the updated entry is written
// back when the request leaves stage 1; a write to the slot that is being
// read in the same cycle is forwarded. Four valid flops stand in for the
// reset contents of the memory, so there is no clearing pass after reset.
// The pot scaling multiply is done in the first stage; the divide by 127 is
// a reciprocal multiply with one correction step in the second stage. Input
// stall rises only when a finished result waits at the output and the
// downstream side is stalling, and configuration is expected to be written
// while no request is in flight.
// ----------------------------------------------------------------------------
module midi_control_change_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mccm_pkg::in_item_t                  in_payload,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mccm_pkg::out_item_t                 out_payload,
  input  logic                                cfg_we,
  input  logic [mccm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mccm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import mccm_pkg::*;

  typedef struct packed {
    in_item_t    item;
    logic [13:0] prod;
  } stage_t;

  // Configuration registers.
  logic [9:0]  thr_r;
  logic [31:0] btn_low_r;
  logic [31:0] btn_high_r;
  logic [25:0] pot_map_r [POT_COUNT];

  // Pipeline and forwarding.
  logic              s1_valid_r;
  stage_t            s1_r;
  logic              fwd_r;
  entry_t            fwd_data_r;
  logic              vld_rd_r;
  logic [SLOT_COUNT-1:0] vld_r;

  logic              out_valid_r;
  out_item_t         out_r;

  logic              accept;
  logic              s1_adv;
  logic              fwd_hit;

  // Stage 0 signals.
  logic [25:0] s0_map;
  logic [6:0]  s0_lo;
  logic [6:0]  s0_hi;
  logic [6:0]  s0_span;
  logic [13:0] s0_prod;

  // Stage 1 signals.
  entry_t      ram_rdata;
  entry_t      ent;
  entry_t      ent_nxt;
  logic        res;
  out_item_t   res_item;
  logic [31:0] btn_word;
  logic [15:0] btn_map;
  logic [25:0] s1_map;
  logic [6:0]  s1_lo;
  logic [6:0]  s1_hi;
  logic        full_range;
  logic [9:0]  sdiff;
  logic [20:0] div_acc;
  logic [6:0]  q_est;
  logic [13:0] q_127;
  logic [13:0] rem;
  logic [6:0]  quot;
  logic [6:0]  pot_val;
  logic        slot_ok;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= THRESHOLD_RST;
      btn_low_r    <= BTN_LOW_RST;
      btn_high_r   <= BTN_HIGH_RST;
      pot_map_r[0] <= POT0_RST;
      pot_map_r[1] <= POT1_RST;
      pot_map_r[2] <= POT2_RST;
      pot_map_r[3] <= POT3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r        <= cfg_wdata[9:0];
        REG_BTN_LOW:   btn_low_r    <= cfg_wdata;
        REG_BTN_HIGH:  btn_high_r   <= cfg_wdata;
        REG_POT0:      pot_map_r[0] <= cfg_wdata[25:0];
        REG_POT1:      pot_map_r[1] <= cfg_wdata[25:0];
        REG_POT2:      pot_map_r[2] <= cfg_wdata[25:0];
        REG_POT3:      pot_map_r[3] <= cfg_wdata[25:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage 1 retires whenever the output register can take its
  // result, whether or not it produces one.
  // --------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign fwd_hit  = s1_adv && (s1_r.item.slot == in_payload.slot);

  // --------------------------------------------------------------------------
  // Stage 0: scaling multiply for pot samples.
  // --------------------------------------------------------------------------
  always_comb begin
    s0_map  = pot_map_r[in_payload.slot];
    s0_lo   = s0_map[18:12];
    s0_hi   = s0_map[25:19];
    s0_span = (s0_lo > s0_hi) ? (s0_lo - s0_hi) : (s0_hi - s0_lo);
    s0_prod = 14'(in_payload.sample[9:3]) * 14'(s0_span);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= fwd_hit;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.item  <= in_payload;
      s1_r.prod  <= s0_prod;
      fwd_data_r <= ent_nxt;
      vld_rd_r   <= vld_r[in_payload.slot];
    end
  end

  // --------------------------------------------------------------------------
  // State memory
  // --------------------------------------------------------------------------
  mccm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.item.slot),
    .wdata (ent_nxt),
    .re    (accept),
    .raddr (in_payload.slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (s1_adv) begin
      vld_r[s1_r.item.slot] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: read-modify-write of the slot entry.
  // --------------------------------------------------------------------------
  always_comb begin
    if (fwd_r) begin
      ent = fwd_data_r;
    end else if (vld_rd_r) begin
      ent = ram_rdata;
    end else begin
      ent = ENTRY_RST;
    end
  end

  always_comb begin
    btn_word   = s1_r.item.slot[1] ? btn_high_r : btn_low_r;
    btn_map    = s1_r.item.slot[0] ? btn_word[31:16] : btn_word[15:0];
    s1_map     = pot_map_r[s1_r.item.slot];
    s1_lo      = (s1_map[18:12] > s1_map[25:19]) ? s1_map[25:19] : s1_map[18:12];
    s1_hi      = (s1_map[18:12] > s1_map[25:19]) ? s1_map[18:12] : s1_map[25:19];
    full_range = (s1_lo == CC_VAL_MIN) && (s1_hi == CC_VAL_MAX);

    // Divide by 127: multiply by 129/16384, then one correction step.
    div_acc = {7'd0, s1_r.prod} + {s1_r.prod, 7'd0};
    q_est   = div_acc[20:14];
    q_127   = {q_est, 7'd0} - {7'd0, q_est};
    rem     = s1_r.prod - q_127;
    quot    = q_est + {6'd0, (rem >= 14'd127)};
    pot_val = full_range ? s1_r.item.sample[9:3] : (quot + s1_lo);

    sdiff = (s1_r.item.sample >= ent.last_sample) ? (s1_r.item.sample - ent.last_sample)
                                                  : (ent.last_sample - s1_r.item.sample);

    ent_nxt  = ent;
    res      = 1'b0;
    res_item = '{status_byte: status_for(btn_map[4:0]),
                 controller_number: btn_map[11:5],
                 controller_value: CC_VAL_MIN};

    if (s1_r.item.command == CMD_BUTTON) begin
      slot_ok = ({1'b0, s1_r.item.slot} < 3'(BUTTON_COUNT));
      if (slot_ok) begin
        if (btn_map[12]) begin
          // Push mode: every edge reports the level.
          res = 1'b1;
          res_item.controller_value = s1_r.item.pressed ? CC_VAL_MAX : CC_VAL_MIN;
        end else if (s1_r.item.pressed) begin
          // Toggle mode: only a press flips the kept bit.
          res            = 1'b1;
          ent_nxt.toggle = ~ent.toggle;
          res_item.controller_value = ent_nxt.toggle ? CC_VAL_MAX : CC_VAL_MIN;
        end
      end
    end else begin
      slot_ok = ({1'b0, s1_r.item.slot} < 3'(POT_COUNT));
      res_item.status_byte       = status_for(s1_map[4:0]);
      res_item.controller_number = s1_map[11:5];
      res_item.controller_value  = pot_val;
      if (slot_ok && (sdiff >= thr_r)) begin
        ent_nxt.last_sample = s1_r.item.sample;
        if ({1'b0, pot_val} != ent.last_value) begin
          res                = 1'b1;
          ent_nxt.last_value = {1'b0, pot_val};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res_item;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result at the output");

  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forwarded entry held with no request in stage one");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload.status_byte[7:4] == CC_STATUS[7:4]))
    else $error("result carries a status byte that is not a control change");
`endif

endmodule

// ----- sv/mccm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory, one write and one read port, registered read data
// that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the MIDI control-change mapper
// Drives button edge events and pot samples through the request channel and
// checks every control-change request that comes back against a typed-in
// result or a behavioral predictor of the mapper. A directed plan covers
// reset behavior, the field extremes and the corner cases. Randomized phases
// with fresh register settings and random idle and stall patterns follow.
// ----------------------------------------------------------------------------
module tb;
  import mccm_pkg::*;

  // A request that gives no result can still be inside the block when the
  // last expected result arrives; this drain covers it with margin before any
  // register write or the end of the run.
  localparam int DRAIN_CYCLES   = 6;
  // No stretch of a correct run comes near this limit without a handshake,
  // since it holds only a request gap, a result stall and the drain, so this
  // many quiet cycles means the block is stuck.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 9;
  localparam int PHASE_REQUESTS = 150;
  localparam int PLAN_LEN       = 34;

  // How often a side holds off: never, on every request, or now and then.
  typedef enum int {
    IDLE_NONE,
    IDLE_FULL,
    IDLE_SPARSE
  } idle_mode_t;

  // A directed row is either a register write or a request. A request row
  // either has its result typed in, is known to give no result, or is left
  // to the predictor.
  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_PREDICT,
    STEP_SILENT,
    STEP_SENDS
  } step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    cfg_reg_t    reg_sel;
    logic [31:0] wdata;
    in_item_t    req;
    out_item_t   resp;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_payload = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_payload;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: the register copies and the per-slot memory.
  logic [9:0]  thr_cfg;
  logic [31:0] btn_cfg [2];
  logic [25:0] pot_cfg [POT_COUNT];
  logic        latch_bit [BUTTON_COUNT];
  logic [9:0]  kept_sample [POT_COUNT];
  logic [7:0]  sent_value [POT_COUNT];

  // Control-change requests that the block still owes us, oldest first.
  out_item_t   pending_cc [$];

  idle_mode_t  in_mode = IDLE_NONE;
  idle_mode_t  out_mode = IDLE_NONE;
  int          stall_left = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  midi_control_change_mapper dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_FULL:   return int'($urandom_range(15, 0));
      IDLE_SPARSE: return ($urandom_range(3, 0) == 0) ? int'($urandom_range(15, 0)) : 0;
      default:     return 0;
    endcase
  endfunction

  // Status byte for a 5-bit channel field. Channel 0 is treated as channel 1
  // and anything above 16 as channel 16.
  function automatic logic [7:0] cc_status(input logic [4:0] chan);
    logic [3:0] nib;
    if (chan == 5'd0) begin
      nib = 4'd0;
    end else if (chan > 5'd16) begin
      nib = 4'd15;
    end else begin
      nib = chan[3:0] - 4'd1;
    end
    return CC_STATUS | {4'd0, nib};
  endfunction

  // Works out what the block sends for one accepted request and updates the
  // predictor state. Returns 1 when a control change goes out.
  function automatic bit predict_cc(input in_item_t req, output out_item_t res);
    logic [15:0] bmap;
    logic [25:0] pmap;
    logic [6:0]  lo;
    logic [6:0]  hi;
    logic [6:0]  swap;
    logic [6:0]  val;
    logic [9:0]  delta;
    int          scaled;
    int          s;
    res = '0;
    s = int'(req.slot);
    if (req.command == CMD_BUTTON) begin
      if (s >= BUTTON_COUNT) return 1'b0;
      bmap = req.slot[0] ? btn_cfg[req.slot[1]][31:16] : btn_cfg[req.slot[1]][15:0];
      if (!bmap[12]) begin
        // Toggle mode acts on presses only; a release leaves the bit alone.
        if (!req.pressed) return 1'b0;
        latch_bit[s] = ~latch_bit[s];
        val = latch_bit[s] ? CC_VAL_MAX : CC_VAL_MIN;
      end else begin
        val = req.pressed ? CC_VAL_MAX : CC_VAL_MIN;
      end
      res = '{cc_status(bmap[4:0]), bmap[11:5], val};
      return 1'b1;
    end
    if (s >= POT_COUNT) return 1'b0;
    delta = (req.sample >= kept_sample[s]) ? req.sample - kept_sample[s]
                                           : kept_sample[s] - req.sample;
    if (delta < thr_cfg) return 1'b0;
    kept_sample[s] = req.sample;
    pmap = pot_cfg[s];
    lo = pmap[18:12];
    hi = pmap[25:19];
    if (lo > hi) begin
      swap = lo;
      lo = hi;
      hi = swap;
    end
    if (lo == 7'd0 && hi == 7'd127) begin
      val = req.sample[9:3];
    end else begin
      scaled = int'(req.sample[9:3]) * int'(hi - lo) / 127 + int'(lo);
      val = scaled[6:0];
    end
    // A value equal to the last one sent for this pot is swallowed.
    if ({1'b0, val} == sent_value[s]) return 1'b0;
    sent_value[s] = {1'b0, val};
    res = '{cc_status(pmap[4:0]), pmap[11:5], val};
    return 1'b1;
  endfunction

  // Drops valid and waits until every owed result is back and any request
  // that gives no result has had time to leave the block.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_cc.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic program_register(input cfg_reg_t sel, input logic [31:0] data);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_THRESHOLD: thr_cfg = data[9:0];
      REG_BTN_LOW:   btn_cfg[0] = data;
      REG_BTN_HIGH:  btn_cfg[1] = data;
      default:       pot_cfg[int'(sel) - int'(REG_POT0)] = data[25:0];
    endcase
  endtask

  // Offers one request after a random gap and returns at the edge where it
  // is taken. Valid stays high when the next request follows with no gap.
  task automatic send_event(input in_item_t req, input step_kind_t kind,
                            input out_item_t given);
    int        gap;
    bit        made;
    out_item_t res;
    gap = draw_wait(in_mode);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_payload <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    made = predict_cc(req, res);
    if (kind == STEP_SENDS) begin
      pending_cc.push_back(given);
    end else if (kind == STEP_PREDICT && made) begin
      pending_cc.push_back(res);
    end
  endtask

  function automatic step_t write_row(input cfg_reg_t sel, input logic [31:0] data);
    return '{STEP_WRITE, sel, data, '0, '0};
  endfunction

  function automatic step_t event_row(input step_kind_t kind, input cmd_t cmd,
                                      input logic [1:0] slot, input logic pressed,
                                      input logic [9:0] sample, input logic [7:0] status,
                                      input logic [6:0] number, input logic [6:0] value);
    return '{kind, REG_THRESHOLD, 32'd0, '{cmd, slot, pressed, sample},
             '{status, number, value}};
  endfunction

  // Results are checked at the edge where they are taken. After each one the
  // receiver picks how many cycles it will stall the next result; the count
  // only runs down while a result is actually waiting, so every stall bites.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cc.size() == 0) begin
        $error("unexpected control change: status %0h number %0d value %0d",
               out_payload.status_byte, out_payload.controller_number,
               out_payload.controller_value);
        mismatches++;
      end else begin
        want = pending_cc.pop_front();
        if (out_payload.status_byte !== want.status_byte) begin
          $error("status_byte: expected %0h, got %0h", want.status_byte,
                 out_payload.status_byte);
          mismatches++;
        end
        if (out_payload.controller_number !== want.controller_number) begin
          $error("controller_number: expected %0d, got %0d", want.controller_number,
                 out_payload.controller_number);
          mismatches++;
        end
        if (out_payload.controller_value !== want.controller_value) begin
          $error("controller_value: expected %0d, got %0d", want.controller_value,
                 out_payload.controller_value);
          mismatches++;
        end
      end
      stall_left = draw_wait(out_mode);
    end else if (out_valid && stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    step_t       plan [PLAN_LEN];
    in_item_t    req;
    int          pick;
    int          reach;
    int          aim;
    logic [9:0]  thr;
    logic [31:0] word;
    logic        btn_level [BUTTON_COUNT];

    thr_cfg    = THRESHOLD_RST;
    btn_cfg[0] = BTN_LOW_RST;
    btn_cfg[1] = BTN_HIGH_RST;
    pot_cfg[0] = POT0_RST;
    pot_cfg[1] = POT1_RST;
    pot_cfg[2] = POT2_RST;
    pot_cfg[3] = POT3_RST;
    for (int i = 0; i < BUTTON_COUNT; i++) begin
      latch_bit[i] = 1'b0;
      btn_level[i] = 1'b0;
    end
    for (int i = 0; i < POT_COUNT; i++) begin
      kept_sample[i] = 10'd0;
      sent_value[i]  = 8'hFF;
    end

    // Directed plan. With the reset settings all buttons toggle on channel 1
    // with numbers 20..23 and all pots use the full range on channel 1 with
    // numbers 30..33, so most results here can be typed in directly.
    plan = '{
      // Toggle mode: press sets, release is silent, next press clears.
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd0, 1'b1, 10'd0,    8'hB0, 7'd20, 7'd127),
      event_row(STEP_SILENT, CMD_BUTTON, 2'd0, 1'b0, 10'd1023, 8'h00, 7'd0,  7'd0),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd0, 1'b1, 10'd0,    8'hB0, 7'd20, 7'd0),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd3, 1'b1, 10'd0,    8'hB0, 7'd23, 7'd127),
      // Pot moves of 3 and 7 stay under the reset threshold of 8.
      event_row(STEP_SENDS,  CMD_POT,    2'd0, 1'b0, 10'd1023, 8'hB0, 7'd30, 7'd127),
      event_row(STEP_SILENT, CMD_POT,    2'd0, 1'b1, 10'd1020, 8'h00, 7'd0,  7'd0),
      event_row(STEP_SENDS,  CMD_POT,    2'd0, 1'b0, 10'd0,    8'hB0, 7'd30, 7'd0),
      event_row(STEP_SILENT, CMD_POT,    2'd0, 1'b0, 10'd7,    8'h00, 7'd0,  7'd0),
      event_row(STEP_SENDS,  CMD_POT,    2'd0, 1'b0, 10'd8,    8'hB0, 7'd30, 7'd1),
      event_row(STEP_SENDS,  CMD_POT,    2'd3, 1'b1, 10'd1023, 8'hB0, 7'd33, 7'd127),
      // Zero threshold; push buttons on channel 0, 16 and 17, the last of them
      // button 3 with its unused bits set, a toggle button on channel 31; pot 0 with
      // every bit set, pot 1 with a reversed range, pot 2 with everything zero.
      write_row(REG_THRESHOLD, 32'hFFFF_FC00),
      write_row(REG_BTN_LOW,   32'h001F_1FE0),
      write_row(REG_BTN_HIGH,  32'hF811_10B0),
      write_row(REG_POT0,      32'hFFFF_FFFF),
      write_row(REG_POT1,      32'h00A6_4FFF),
      write_row(REG_POT2,      32'h0000_0000),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd0, 1'b1, 10'd0,    8'hB0, 7'd127, 7'd127),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd0, 1'b0, 10'd0,    8'hB0, 7'd127, 7'd0),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd1, 1'b1, 10'd0,    8'hBF, 7'd0,   7'd127),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd2, 1'b0, 10'd0,    8'hBF, 7'd5,   7'd0),
      event_row(STEP_SENDS,  CMD_BUTTON, 2'd3, 1'b1, 10'd0,    8'hBF, 7'd64,  7'd127),
      event_row(STEP_SENDS,  CMD_POT,    2'd1, 1'b0, 10'd1023, 8'hBF, 7'd127, 7'd100),
      event_row(STEP_SILENT, CMD_POT,    2'd1, 1'b0, 10'd1023, 8'h00, 7'd0,   7'd0),
      event_row(STEP_SENDS,  CMD_POT,    2'd1, 1'b0, 10'd0,    8'hBF, 7'd127, 7'd20),
      event_row(STEP_SENDS,  CMD_POT,    2'd2, 1'b0, 10'd512,  8'hB0, 7'd0,   7'd0),
      event_row(STEP_SENDS,  CMD_POT,    2'd0, 1'b0, 10'd5,    8'hBF, 7'd127, 7'd127),
      // Largest threshold: only a full-scale swing counts.
      write_row(REG_THRESHOLD, 32'h0000_03FF),
      event_row(STEP_SENDS,  CMD_POT,    2'd3, 1'b0, 10'd0,    8'hB0, 7'd33, 7'd0),
      event_row(STEP_SILENT, CMD_POT,    2'd3, 1'b0, 10'd1022, 8'h00, 7'd0,  7'd0),
      event_row(STEP_SENDS,  CMD_POT,    2'd3, 1'b0, 10'd1023, 8'hB0, 7'd33, 7'd127),
      // A range of 3 to 90 on channel 9, left to the predictor.
      write_row(REG_THRESHOLD, 32'h0000_0005),
      write_row(REG_POT2,      32'h02D0_39A9),
      event_row(STEP_PREDICT, CMD_POT,   2'd2, 1'b1, 10'd700,  8'h00, 7'd0,  7'd0),
      event_row(STEP_PREDICT, CMD_POT,   2'd2, 1'b0, 10'd333,  8'h00, 7'd0,  7'd0)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    in_mode  = IDLE_FULL;
    out_mode = IDLE_FULL;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        program_register(plan[i].reg_sel, plan[i].wdata);
      end else begin
        send_event(plan[i].req, plan[i].kind, plan[i].resp);
      end
    end

    // Random phases. The first runs at full rate with everything set to ones
    // and a zero threshold, the second with everything zero and the largest
    // threshold; the rest draw settings and idle patterns at random.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        thr = 10'd0;
      end else if (phase == 1) begin
        thr = 10'd1023;
      end else begin
        pick = int'($urandom_range(5, 0));
        if (pick == 0) begin
          thr = 10'd0;
        end else if (pick == 1) begin
          thr = 10'($urandom_range(1023, 0));
        end else begin
          thr = 10'($urandom_range(40, 0));
        end
      end
      program_register(REG_THRESHOLD, {22'($urandom), thr});
      for (int k = 0; k < 2 + POT_COUNT; k++) begin
        word = $urandom;
        if (phase == 0) begin
          word = 32'hFFFF_FFFF;
        end else if (phase == 1) begin
          word = 32'h0000_0000;
        end else if (k >= 2) begin
          // Pots often get the full range, either way round.
          pick = int'($urandom_range(7, 0));
          if (pick < 2) begin
            word[25:12] = {7'd127, 7'd0};
          end else if (pick == 2) begin
            word[25:12] = {7'd0, 7'd127};
          end
        end
        program_register(cfg_reg_t'(int'(REG_BTN_LOW) + k), word);
      end

      if (phase == 0) begin
        in_mode  = IDLE_NONE;
        out_mode = IDLE_NONE;
      end else if (phase == 1) begin
        in_mode  = IDLE_FULL;
        out_mode = IDLE_FULL;
      end else begin
        in_mode  = idle_mode_t'($urandom_range(2, 0));
        out_mode = idle_mode_t'($urandom_range(2, 0));
      end

      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        req.command = 1'($urandom_range(1, 0));
        req.slot    = 2'($urandom_range(3, 0));
        req.pressed = 1'($urandom_range(1, 0));
        req.sample  = 10'($urandom_range(1023, 0));
        if (req.command == CMD_BUTTON) begin
          // Mostly real edges: the level flips from what this button last saw.
          if ($urandom_range(4, 0) != 0) req.pressed = ~btn_level[req.slot];
          btn_level[req.slot] = req.pressed;
        end else begin
          pick = int'($urandom_range(9, 0));
          if (pick < 5) begin
            // Land just around the threshold from the last kept sample.
            reach = int'(thr_cfg) + int'($urandom_range(4, 0)) - 2;
            if (reach < 0) reach = 0;
            aim = int'(kept_sample[req.slot]);
            aim = ($urandom_range(1, 0) == 1) ? aim + reach : aim - reach;
            if (aim > 1023) aim = int'(kept_sample[req.slot]) - reach;
            if (aim < 0) aim = int'(kept_sample[req.slot]) + reach;
            if (aim >= 0 && aim <= 1023) req.sample = 10'(aim);
          end else if (pick < 7) begin
            req.sample = ($urandom_range(1, 0) == 1) ? 10'd1023 : 10'd0;
          end
        end
        send_event(req, STEP_PREDICT, '0);
      end
    end

    drain_pipeline();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mccm_pkg.sv
sv/mccm_ram.sv
sv/midi_control_change_mapper.sv
dv/tb.sv
